// ===== rtl/core/rarrip_pkg.sv =====
package rarrip_pkg;

    // Field widths of the item channels
    localparam int SET_W       = 11;
    localparam int WAY_FIELD_W = 4;
    localparam int INS_FIELD_W = 2;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int THR_W      = 7;
    localparam int WLEN_W     = 16;
    localparam int TEMP_W     = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_MISS_PCT = 2'd0;
    localparam cfg_idx_t CFG_WIN_LEN  = 2'd1;
    localparam cfg_idx_t CFG_TEMPORAL = 2'd2;

    localparam logic [THR_W-1:0]  MISS_PCT_DEFAULT = 7'd60;
    localparam logic [WLEN_W-1:0] WIN_LEN_DEFAULT  = 16'd2048;
    localparam logic [TEMP_W-1:0] TEMPORAL_DEFAULT = 3'd4;

    // Per-set reuse counter
    localparam int REUSE_W = 3;
    localparam logic [REUSE_W-1:0] REUSE_MAX   = 3'd7;
    localparam logic [REUSE_W-1:0] REUSE_RESET = 3'd3;

    // Window counters and miss percentage scale
    localparam int CNT_W   = 16;
    localparam int SCALE_W = 23;
    localparam logic [6:0] PCT_SCALE = 7'd100;

    // Item kinds
    localparam logic KIND_VICTIM = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

endpackage

// ===== rtl/core/rarrip_ram.sv =====
module rarrip_ram #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 2048
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/reuse_aware_rrip_replacement_core.sv =====
// Channel   | Direction | Ports                                   | Contents
// ----------+-----------+-----------------------------------------+---------------------------
// request   | in        | s_tvalid, s_tready, s_tdata, s_tuser    | victim request or update
// result    | out       | m_tvalid, m_tready, m_tdata             | victim, insertion RRPV, mode
// config    | in        | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes
//
// An item has an accept cycle, which reads the set's entry from the state memory, and then
// a modify cycle, which modifies it and writes it back; the single memory port pair sets this.
// After reset a clearing pass writes every set's reset entry with s_tready low;
// configuration writes are taken throughout.
// A result waits in the output register; the modify cycle holds while that register
// is still full and m_tready is low, so one stalled item is absorbed.
module reuse_aware_rrip_replacement_core #(
    parameter int NUM_SETS  = 2048,
    parameter int NUM_WAYS  = 16,
    parameter int RRPV_BITS = 2
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // s_tdata: set_index [10:0], way_index [14:11], hit_flag [15]
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [rarrip_pkg::S_TDATA_W-1:0]        s_tdata,
    // s_tuser: kind [0]
    input  logic [rarrip_pkg::S_TUSER_W-1:0]        s_tuser,
    // m_tdata: victim_way [3:0], insert_rrpv [5:4], streaming_mode [6], zero [7]
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [rarrip_pkg::M_TDATA_W-1:0]        m_tdata,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  rarrip_pkg::cfg_idx_t                    cfg_index,
    input  logic [rarrip_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int AW      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W   = $clog2(NUM_WAYS);
    localparam int RRPV_W  = NUM_WAYS * RRPV_BITS;
    localparam int ENTRY_W = RRPV_W + NUM_WAYS + rarrip_pkg::REUSE_W;
    localparam int RED_W   = (AW > rarrip_pkg::SET_W) ? AW : rarrip_pkg::SET_W;
    localparam int SET_SPAN = 1 << rarrip_pkg::SET_W;

    localparam logic [RRPV_BITS-1:0] RRPV_MAX   = '1;
    localparam logic [RRPV_BITS-1:0] RRPV_MID   = RRPV_BITS'(1);
    localparam logic [RRPV_BITS-1:0] RRPV_SHORT = '0;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    // Entry layout: RRPVs in the low bits, then valid bits, then the reuse counter
    localparam logic [ENTRY_W-1:0] ENTRY_RESET =
        {rarrip_pkg::REUSE_RESET, {NUM_WAYS{1'b0}}, {RRPV_W{1'b1}}};

    // ------------------------------------------------------------------
    // Control and configuration state
    // ------------------------------------------------------------------
    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic [rarrip_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [rarrip_pkg::THR_W-1:0]  thr_reg;
    logic [rarrip_pkg::WLEN_W-1:0] win_len_reg;
    logic [rarrip_pkg::TEMP_W-1:0] temporal_reg;

    logic [rarrip_pkg::CNT_W-1:0] acc_reg, acc_next;
    logic [rarrip_pkg::CNT_W-1:0] miss_reg, miss_next;
    logic                         flag_reg, flag_next;

    // Item held across the modify cycle
    logic                                kind_reg;
    logic [AW-1:0]                       addr_reg;
    logic [rarrip_pkg::WAY_FIELD_W-1:0]  way_reg;
    logic                                hit_reg;

    logic accept;
    logic exec_go;

    // ------------------------------------------------------------------
    // Input unpack and set reduction
    // ------------------------------------------------------------------
    logic [rarrip_pkg::SET_W-1:0] set_in;
    logic [RED_W-1:0]             set_red;

    assign set_in = s_tdata[rarrip_pkg::SET_W-1:0];

    // Fold the set index into range: conditional subtraction of shifted set counts
    always_comb begin
        set_red = RED_W'(set_in);
        for (int k = rarrip_pkg::SET_W - 1; k >= 0; k--) begin
            if ((NUM_SETS << k) < SET_SPAN) begin
                if (32'(set_red) >= (NUM_SETS << k)) begin
                    set_red = set_red - RED_W'(NUM_SETS << k);
                end
            end
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign exec_go   = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // State memory
    // ------------------------------------------------------------------
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] entry_new;

    assign ram_we    = (state_reg == ST_CLEAR) || exec_go;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? ENTRY_RESET : entry_new;

    rarrip_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SETS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (set_red[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Entry unpack
    // ------------------------------------------------------------------
    logic [RRPV_BITS-1:0]          rrpv_old [NUM_WAYS];
    logic [NUM_WAYS-1:0]           valid_old;
    logic [rarrip_pkg::REUSE_W-1:0] lvl_old;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            rrpv_old[w] = ram_rdata[w*RRPV_BITS +: RRPV_BITS];
        end
    end
    assign valid_old = ram_rdata[RRPV_W +: NUM_WAYS];
    assign lvl_old   = ram_rdata[RRPV_W + NUM_WAYS +: rarrip_pkg::REUSE_W];

    // ------------------------------------------------------------------
    // Victim selection: first invalid way, else first way at the set's top RRPV,
    // with every way lifted so that top reaches the maximum
    // ------------------------------------------------------------------
    logic                 any_invalid;
    logic [WAY_W-1:0]     first_inv;
    logic [NUM_WAYS-1:0]  top_cand;
    logic [WAY_W-1:0]     top_way;
    logic [RRPV_BITS-1:0] lift;
    logic [WAY_W-1:0]     victim_way;
    logic [RRPV_W-1:0]    rrpv_victim;

    always_comb begin
        logic [NUM_WAYS-1:0] bit_mask;
        any_invalid = ~&valid_old;
        first_inv   = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (!valid_old[w]) begin
                first_inv = WAY_W'(w);
            end
        end
        // Narrow the candidate set one RRPV bit at a time, from the top bit down
        top_cand = '1;
        for (int b = RRPV_BITS - 1; b >= 0; b--) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                bit_mask[w] = top_cand[w] & rrpv_old[w][b];
            end
            if (|bit_mask) begin
                top_cand = bit_mask;
            end
        end
        top_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (top_cand[w]) begin
                top_way = WAY_W'(w);
            end
        end
        lift = RRPV_MAX - rrpv_old[top_way];
        for (int w = 0; w < NUM_WAYS; w++) begin
            rrpv_victim[w*RRPV_BITS +: RRPV_BITS] =
                any_invalid ? rrpv_old[w] : rrpv_old[w] + lift;
        end
        victim_way = any_invalid ? first_inv : top_way;
    end

    // ------------------------------------------------------------------
    // Miss window
    // ------------------------------------------------------------------
    logic [rarrip_pkg::CNT_W-1:0]   acc_inc;
    logic [rarrip_pkg::CNT_W-1:0]   miss_inc;
    logic [rarrip_pkg::THR_W:0]     thr_plus1;
    logic [rarrip_pkg::SCALE_W-1:0] miss_scaled;
    logic [rarrip_pkg::SCALE_W-1:0] acc_scaled;
    logic                           win_close;
    logic                           miss_above;

    assign acc_inc   = acc_reg + 1'b1;
    assign miss_inc  = miss_reg + rarrip_pkg::CNT_W'(!hit_reg);
    assign win_close = (acc_inc >= win_len_reg);
    assign thr_plus1 = {1'b0, thr_reg} + 1'b1;

    // misses*100/accesses > thr holds exactly when misses*100 >= (thr+1)*accesses
    assign miss_scaled = rarrip_pkg::SCALE_W'(miss_inc) *
                         rarrip_pkg::SCALE_W'(rarrip_pkg::PCT_SCALE);
    assign acc_scaled  = rarrip_pkg::SCALE_W'(thr_plus1) *
                         rarrip_pkg::SCALE_W'(acc_inc);
    assign miss_above  = (acc_inc != '0) && (miss_scaled >= acc_scaled);

    always_comb begin
        acc_next  = acc_reg;
        miss_next = miss_reg;
        flag_next = flag_reg;
        if (exec_go && kind_reg == rarrip_pkg::KIND_UPDATE) begin
            if (win_close) begin
                acc_next  = '0;
                miss_next = '0;
                flag_next = miss_above;
            end else begin
                acc_next  = acc_inc;
                miss_next = miss_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Update: reuse counter, insertion RRPV, way write
    // ------------------------------------------------------------------
    logic [rarrip_pkg::REUSE_W-1:0] lvl_new;
    logic [RRPV_BITS-1:0]           ins_rrpv;
    logic                           way_in_range;
    logic [RRPV_W-1:0]              rrpv_update;
    logic [NUM_WAYS-1:0]            valid_update;

    always_comb begin
        lvl_new = lvl_old;
        if (hit_reg) begin
            if (lvl_old < rarrip_pkg::REUSE_MAX) begin
                lvl_new = lvl_old + 1'b1;
            end
        end else if (lvl_old != '0) begin
            lvl_new = lvl_old - 1'b1;
        end

        // Streaming mode uses the flag as left by this update's window step
        if (flag_next) begin
            ins_rrpv = RRPV_MAX;
        end else if (lvl_new >= temporal_reg) begin
            ins_rrpv = RRPV_SHORT;
        end else if (lvl_new != '0) begin
            ins_rrpv = RRPV_MID;
        end else begin
            ins_rrpv = RRPV_MAX;
        end

        way_in_range = (32'(way_reg) < NUM_WAYS);
        rrpv_update  = ram_rdata[RRPV_W-1:0];
        valid_update = valid_old;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (way_in_range && 32'(way_reg) == w) begin
                rrpv_update[w*RRPV_BITS +: RRPV_BITS] = ins_rrpv;
                valid_update[w] = 1'b1;
            end
        end
    end

    assign entry_new = (kind_reg == rarrip_pkg::KIND_UPDATE) ?
                       {lvl_new, valid_update, rrpv_update} :
                       {lvl_old, valid_old, rrpv_victim};

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(NUM_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until taken; load a new one when the modify cycle completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec_go) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            acc_reg      <= '0;
            miss_reg     <= '0;
            flag_reg     <= 1'b0;
            thr_reg      <= rarrip_pkg::MISS_PCT_DEFAULT;
            win_len_reg  <= rarrip_pkg::WIN_LEN_DEFAULT;
            temporal_reg <= rarrip_pkg::TEMPORAL_DEFAULT;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
            miss_reg    <= miss_next;
            flag_reg    <= flag_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rarrip_pkg::CFG_MISS_PCT: thr_reg      <= cfg_data[rarrip_pkg::THR_W-1:0];
                    rarrip_pkg::CFG_WIN_LEN:  win_len_reg  <= cfg_data[rarrip_pkg::WLEN_W-1:0];
                    rarrip_pkg::CFG_TEMPORAL: temporal_reg <= cfg_data[rarrip_pkg::TEMP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_tuser[0];
            addr_reg <= set_red[AW-1:0];
            way_reg  <= s_tdata[rarrip_pkg::SET_W +: rarrip_pkg::WAY_FIELD_W];
            hit_reg  <= s_tdata[rarrip_pkg::SET_W + rarrip_pkg::WAY_FIELD_W];
        end
        if (exec_go) begin
            if (kind_reg == rarrip_pkg::KIND_UPDATE) begin
                m_data_reg <= {1'b0, flag_next, rarrip_pkg::INS_FIELD_W'(ins_rrpv),
                               {rarrip_pkg::WAY_FIELD_W{1'b0}}};
            end else begin
                m_data_reg <= {1'b0, flag_next, {rarrip_pkg::INS_FIELD_W{1'b0}},
                               rarrip_pkg::WAY_FIELD_W'(victim_way)};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/core/rarrip_checker.sv =====
module rarrip_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [rarrip_pkg::M_TDATA_W-1:0]   m_tdata
);

    // A stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // One item in flight: the block is busy in the cycle after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item in modify cycle");

    // A result is either a victim choice or an insertion, never both
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] == 4'd0 || m_tdata[5:4] == 2'd0))
        else $error("victim and insertion both non-zero");

    // Padding bit stays clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[7])
        else $error("result padding bit set");

endmodule

bind reuse_aware_rrip_replacement_core rarrip_checker u_rarrip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
